@@ rtl/core/fractal_gradient_noise_2d_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the fractal gradient noise core
// Shared assertion forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef FRACTAL_GRADIENT_NOISE_2D_ASSERT_SVH
`define FRACTAL_GRADIENT_NOISE_2D_ASSERT_SVH

// Condition b must hold in the same cycle as condition a.
`define FGN_ASSERT_SAME(lbl, cond_a, cond_b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("fgn assertion failed (same cycle)");

// Condition b must hold in the cycle after condition a.
`define FGN_ASSERT_NEXT(lbl, cond_a, cond_b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("fgn assertion failed (next cycle)");

`endif

@@ rtl/core/fgn_pkg.sv @@
// ---------------------------------------------------------------------------
// Fractal gradient noise package
// Constants, state codes, status types and the gradient ROM contents.
// ---------------------------------------------------------------------------
package fgn_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TABLE_W    = 8;
  localparam int QUARTER    = TABLE_SIZE / 4;

  // Request operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic [63:0] FREQ_Q32 = 64'd214748365;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int NUM_W  = 48;
  localparam int QUO_W  = 32;
  localparam int ROOT_W = 16;
  localparam int FREQ_W = 28;

  localparam int STATE_W = 23;

  typedef enum logic [STATE_W-1:0] {
    S_IDLE = 23'd1 << 0,
    S_SCX  = 23'd1 << 1,
    S_SCY  = 23'd1 << 2,
    S_SCL  = 23'd1 << 3,
    S_OCT  = 23'd1 << 4,
    S_RD1  = 23'd1 << 5,
    S_RD2  = 23'd1 << 6,
    S_GRAD = 23'd1 << 7,
    S_DXX  = 23'd1 << 8,
    S_DYY  = 23'd1 << 9,
    S_D2   = 23'd1 << 10,
    S_SQRT = 23'd1 << 11,
    S_DD   = 23'd1 << 12,
    S_DCU  = 23'd1 << 13,
    S_NEG  = 23'd1 << 14,
    S_GXD  = 23'd1 << 15,
    S_GYD  = 23'd1 << 16,
    S_DOT  = 23'd1 << 17,
    S_SURF = 23'd1 << 18,
    S_ACC  = 23'd1 << 19,
    S_RND  = 23'd1 << 20,
    S_DIV  = 23'd1 << 21,
    S_EMIT = 23'd1 << 22
  } state_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } isqrt_res_t;

  typedef logic signed [15:0] grad_t;
  typedef grad_t grad_rom_t [TABLE_SIZE];
  typedef logic [63:0] dens_t [6];

  localparam dens_t DENS = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Sine over the first quarter wave in Q2.14, by a Horner-form Taylor series
  // evaluated in Q2.30 and rounded to nearest.
  function automatic logic [15:0] quarter_sine(input logic [31:0] r);
    logic [63:0] ang;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    int          i;
    ang = (64'(r) * 64'd2 * PI_Q30) / TABLE_SIZE;
    a2  = (ang * ang) >> 30;
    t   = ONE_Q30;
    for (i = 0; i < 6; i++) begin
      t = ONE_Q30 - (((a2 * t) >> 30) / DENS[i]);
    end
    s = (ang * t) >> 30;
    return 16'((s + 64'd32768) >> 16);
  endfunction

  function automatic grad_t table_sine(input int unsigned idx);
    int unsigned p;
    int unsigned quad;
    int unsigned r;
    logic [15:0] mag;
    p    = idx % TABLE_SIZE;
    quad = p / QUARTER;
    r    = p % QUARTER;
    mag  = quad[0] ? quarter_sine(32'(QUARTER - r)) : quarter_sine(32'(r));
    return (quad >= 2) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic grad_rom_t build_grad(input bit cosine);
    grad_rom_t rom;
    int        i;
    for (i = 0; i < TABLE_SIZE; i++) begin
      rom[i] = table_sine(i + (cosine ? QUARTER : 0));
    end
    return rom;
  endfunction

  localparam grad_rom_t GRAD_X_ROM = build_grad(1'b1);
  localparam grad_rom_t GRAD_Y_ROM = build_grad(1'b0);

endpackage

@@ rtl/core/fgn_in_if.sv @@
// ---------------------------------------------------------------------------
// Noise request channel
// Valid/ready channel carrying one table load or one sample point.
// ---------------------------------------------------------------------------
interface fgn_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         table_index;
  logic [7:0]         table_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (
    output valid, operation, table_index, table_value, x_coord, y_coord,
    input  ready
  );
  modport sink (
    input  valid, operation, table_index, table_value, x_coord, y_coord,
    output ready
  );
endinterface

@@ rtl/core/fgn_out_if.sv @@
// ---------------------------------------------------------------------------
// Noise result channel
// Valid/ready channel carrying one normalised noise sample.
// ---------------------------------------------------------------------------
interface fgn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

@@ rtl/core/fgn_isqrt.sv @@
// ---------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 32-bit value, one bit pair per cycle.
// ---------------------------------------------------------------------------
module fgn_isqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        value,
  output fgn_pkg::isqrt_res_t res
);
  import fgn_pkg::*;

  logic        busy;
  logic        done;
  logic [31:0] rem_v;
  logic [31:0] root;
  logic [31:0] bitv;
  logic [3:0]  cnt;
  logic [31:0] trial;

  assign trial = root + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem_v <= value;
        root  <= '0;
        bitv  <= 32'd1 << 30;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (rem_v >= trial) begin
          rem_v <= rem_v - trial;
          root  <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.root = root[ROOT_W-1:0];

endmodule

@@ rtl/core/fractal_gradient_noise_2d.sv @@
// ---------------------------------------------------------------------------
// Fractal 2D gradient noise
// A load item writes one permutation entry and is taken without leaving the
// idle state. A point item is worked through one shared signed 33x33
// multiplier under a sequencer: scaling of both coordinates, then per octave a
// setup step plus, for each of the four corners, the table reads and the
// squared distance, and, when the corner lies within unit distance, the
// bit-pair square root, the fade polynomial, the gradient dot product and the
// accumulation; a multiplication by the reciprocal of the octave weight sum
// and an output step close the item. The request channel is ready only while
// no point is in progress; a finished result waits in the output register
// while the next item is taken.
// ---------------------------------------------------------------------------
module fractal_gradient_noise_2d #(
  parameter int OCTAVE_COUNT = 5
) (
  input logic       clk,
  input logic       rst,
  fgn_in_if.sink    items,
  fgn_out_if.source results
);
  import fgn_pkg::*;

  `include "fractal_gradient_noise_2d_assert.svh"

  localparam int K_W      = (OCTAVE_COUNT > 1) ? $clog2(OCTAVE_COUNT) : 1;
  localparam int LAST_OCT = OCTAVE_COUNT - 1;
  localparam int DEN      = (1 << OCTAVE_COUNT) - 1;
  localparam logic [NUM_W-1:0] HALF_DIV = NUM_W'(DEN) << 15;
  // The dividend is clamped just past the saturation point, which keeps the
  // reciprocal product (scaled by 2^31) exact for every weight sum.
  localparam logic [QUO_W-1:0] DIV_CLAMP = QUO_W'(32769 * DEN);
  localparam logic [MUL_W-1:0] DIV_RECIP =
    MUL_W'(((64'd1 << 31) + 64'(DEN) - 64'd1) / 64'(DEN));

  state_t state;

  logic [K_W-1:0]    k;
  logic [1:0]        corner;
  logic [31:0]       ax;
  logic [31:0]       ay;
  logic [63:0]       px;
  logic [63:0]       py;
  logic [7:0]        xi_lo;
  logic [7:0]        yi_lo;
  logic [15:0]       fx;
  logic [15:0]       fy;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  grad_t             gx;
  grad_t             gy;
  logic [33:0]       d2;
  logic [15:0]       d;
  logic [19:0]       p;
  logic [16:0]       fade;
  logic signed [32:0] dotx;
  logic signed [32:0] dot;
  logic signed [PROD_W-1:0] mprod;
  logic signed [NUM_W-1:0]  num;
  logic [QUO_W-1:0]  quo;
  logic              div_cnt;
  logic              neg_res;
  logic              out_valid;
  logic signed [15:0] out_value;

  logic [TABLE_W-1:0] perm_mem [TABLE_SIZE];
  logic [TABLE_W-1:0] perm_addr;
  logic [TABLE_W-1:0] perm_rdata;

  logic signed [MUL_W-1:0] ma;
  logic signed [MUL_W-1:0] mb;

  logic        in_fire;
  logic        cx;
  logic        cy;
  logic        last_corner;
  logic        last_oct;
  logic [4:0]  sh;
  logic [63:0] sx;
  logic [63:0] sy;
  logic [33:0] d2sum;
  logic        sqrt_start;
  isqrt_res_t  sq_res;
  logic [39:0] qwide;
  logic [19:0] neg;
  logic signed [PROD_W-1:0] surf_biased;
  logic signed [NUM_W-1:0]  surf;
  logic [K_W-1:0]           wshift;
  logic [NUM_W-1:0]         mag;
  logic [NUM_W-1:0]         rnd;
  logic signed [15:0]       sat_value;
  logic                     out_free;

  assign in_fire     = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);
  assign cx          = corner[0];
  assign cy          = corner[1];
  assign last_corner = (corner == 2'd3);
  assign last_oct    = (k == K_W'(LAST_OCT));
  assign out_free    = !out_valid || results.ready;

  // Per-octave scaling: the frequency doubles, so the shift shrinks by one.
  assign sh = 5'd16 - 5'(k);
  assign sx = px >> sh;
  assign sy = py >> sh;

  assign d2sum      = d2 + mprod[33:0];
  assign sqrt_start = (state == S_D2) && (d2sum[33:32] == 2'b00);

  // q = (15 d - 6 d^2) in Q4.16, with d^2 the full product from the multiplier.
  assign qwide = (40'(d) << 20) - (40'(d) << 16)
               - ((40'(mprod[31:0]) << 2) + (40'(mprod[31:0]) << 1));
  assign neg   = mprod[35:16];

  // Division by 2^16 rounding toward zero.
  assign surf_biased = mprod + (mprod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign surf        = surf_biased[NUM_W+15:16];
  assign wshift      = K_W'(LAST_OCT) - k;

  assign mag       = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rnd       = (mag + HALF_DIV) >> 16;

  always_comb begin
    if (neg_res) begin
      sat_value = (quo > QUO_W'(32768)) ? -16'sd32768 : -$signed(quo[15:0]);
    end else begin
      sat_value = (quo > QUO_W'(32767)) ? 16'sd32767 : $signed(quo[15:0]);
    end
  end

  always_comb begin
    unique case (state)
      S_RD1:   perm_addr = xi_lo + TABLE_W'(cx);
      S_RD2:   perm_addr = perm_rdata + yi_lo + TABLE_W'(cy);
      default: perm_addr = xi_lo;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_SCX: begin
        ma = $signed({1'b0, ax});
        mb = $signed(MUL_W'(FREQ_Q32[FREQ_W-1:0]));
      end
      S_SCY: begin
        ma = $signed({1'b0, ay});
        mb = $signed(MUL_W'(FREQ_Q32[FREQ_W-1:0]));
      end
      S_DXX: begin
        ma = MUL_W'(dx);
        mb = MUL_W'(dx);
      end
      S_DYY: begin
        ma = MUL_W'(dy);
        mb = MUL_W'(dy);
      end
      S_DD: begin
        ma = $signed(MUL_W'(d));
        mb = $signed(MUL_W'(d));
      end
      S_DCU: begin
        ma = $signed(MUL_W'(mprod[31:16]));
        mb = $signed(MUL_W'(d));
      end
      S_NEG: begin
        ma = $signed(MUL_W'(mprod[31:16]));
        mb = $signed(MUL_W'(p));
      end
      S_GXD: begin
        ma = MUL_W'(gx);
        mb = MUL_W'(dx);
      end
      S_GYD: begin
        ma = MUL_W'(gy);
        mb = MUL_W'(dy);
      end
      S_SURF: begin
        ma = $signed(MUL_W'(fade));
        mb = dot;
      end
      S_DIV: begin
        ma = $signed({1'b0, quo});
        mb = $signed(DIV_RECIP);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (in_fire && (items.operation == OP_LOAD)) begin
      perm_mem[items.table_index] <= items.table_value;
    end
    perm_rdata <= perm_mem[perm_addr];
  end

  fgn_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (d2sum[31:0]),
    .res   (sq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && (items.operation == OP_POINT)) begin
            ax    <= items.x_coord[31] ? 32'(-items.x_coord) : 32'(items.x_coord);
            ay    <= items.y_coord[31] ? 32'(-items.y_coord) : 32'(items.y_coord);
            k     <= '0;
            num   <= '0;
            state <= S_SCX;
          end
        end
        S_SCX: state <= S_SCY;
        S_SCY: begin
          px    <= mprod[63:0];
          state <= S_SCL;
        end
        S_SCL: begin
          py    <= mprod[63:0];
          state <= S_OCT;
        end
        S_OCT: begin
          xi_lo  <= sx[39:32];
          yi_lo  <= sy[39:32];
          fx     <= sx[31:16];
          fy     <= sy[31:16];
          corner <= 2'd0;
          state  <= S_RD1;
        end
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_GRAD;
        S_GRAD: begin
          gx    <= GRAD_X_ROM[perm_rdata];
          gy    <= GRAD_Y_ROM[perm_rdata];
          dx    <= cx ? $signed({2'b00, fx}) - 18'sd65536 : $signed({2'b00, fx});
          dy    <= cy ? $signed({2'b00, fy}) - 18'sd65536 : $signed({2'b00, fy});
          state <= S_DXX;
        end
        S_DXX: state <= S_DYY;
        S_DYY: begin
          d2    <= mprod[33:0];
          state <= S_D2;
        end
        S_D2: begin
          if (sqrt_start) begin
            state <= S_SQRT;
          end else if (!last_corner) begin
            corner <= corner + 2'd1;
            state  <= S_RD1;
          end else if (!last_oct) begin
            k     <= k + K_W'(1);
            state <= S_OCT;
          end else begin
            state <= S_RND;
          end
        end
        S_SQRT: begin
          if (sq_res.done) begin
            d     <= sq_res.root;
            state <= S_DD;
          end
        end
        S_DD: state <= S_DCU;
        S_DCU: begin
          p     <= 20'd655360 - qwide[35:16];
          state <= S_NEG;
        end
        S_NEG: state <= S_GXD;
        S_GXD: begin
          fade  <= (neg >= 20'd65536) ? 17'd0 : 17'(20'd65536 - neg);
          state <= S_GYD;
        end
        S_GYD: begin
          dotx  <= mprod[32:0];
          state <= S_DOT;
        end
        S_DOT: begin
          dot   <= dotx + mprod[32:0];
          state <= S_SURF;
        end
        S_SURF: state <= S_ACC;
        S_ACC: begin
          num <= num + (surf <<< wshift);
          if (!last_corner) begin
            corner <= corner + 2'd1;
            state  <= S_RD1;
          end else if (!last_oct) begin
            k     <= k + K_W'(1);
            state <= S_OCT;
          end else begin
            state <= S_RND;
          end
        end
        S_RND: begin
          quo     <= (rnd > NUM_W'(DIV_CLAMP)) ? DIV_CLAMP : rnd[QUO_W-1:0];
          div_cnt <= 1'b0;
          neg_res <= num[NUM_W-1];
          state   <= S_DIV;
        end
        S_DIV: begin
          // The product started while div_cnt is low is read from the multiplier register while div_cnt is high.
          if (div_cnt) begin
            quo   <= mprod[QUO_W+30:31];
            state <= S_EMIT;
          end
          div_cnt <= !div_cnt;
        end
        S_EMIT: begin
          if (out_free) begin
            out_value <= sat_value;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid       = out_valid;
  assign results.noise_value = out_value;

  `FGN_ASSERT_SAME(a_sqrt_owned, sq_res.done, state == S_SQRT)
  `FGN_ASSERT_SAME(a_div_clamped, state == S_DIV, quo <= DIV_CLAMP)
  `FGN_ASSERT_NEXT(a_octave_start, state == S_OCT, state == S_RD1 && corner == 2'd0)
  `FGN_ASSERT_NEXT(a_emit_loads, state == S_EMIT && out_free, results.valid)

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Fractal gradient noise testbench
// Fills the permutation table, then sends directed and random table loads
// and sample points. Every sample is predicted here in fixed point and
// compared with the noise value that comes back.
// ---------------------------------------------------------------------------
module testbench;
  import fgn_pkg::*;

  localparam int OCTAVES = 5;
  localparam longint unsigned FREQ = 64'd214748365;
  localparam longint unsigned PI30 = 64'd3373259426;
  localparam longint unsigned ONE30 = 64'd1073741824;
  localparam longint unsigned ONE16 = 64'd65536;

  typedef struct {
    logic        operation;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    bit          drain;
  } request_t;

  logic clk;
  logic rst;

  fgn_in_if  items_if ();
  fgn_out_if results_if ();

  fractal_gradient_noise_2d #(.OCTAVE_COUNT(OCTAVES)) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  request_t           pending_requests[$];
  logic signed [15:0] expected_noise[$];
  logic [7:0]         perm[256];
  logic signed [15:0] cos_rom[256];
  logic signed [15:0] sin_rom[256];
  int                 error_count;
  int                 accepted_count;
  int                 loads_sent;
  int                 points_sent;
  int                 results_checked;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 recv_hold;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Quarter-wave sine in Q2.14 from a Horner-form series in Q2.30.
  function automatic logic signed [15:0] sine_quarter(input int unsigned r);
    longint unsigned ang;
    longint unsigned a2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned dens[6];
    dens = '{156, 110, 72, 42, 20, 6};
    ang = (longint'(r) * 2 * PI30) / 256;
    a2 = (ang * ang) >> 30;
    t = ONE30;
    for (int i = 0; i < 6; i++) t = ONE30 - (((a2 * t) >> 30) / dens[i]);
    s = (ang * t) >> 30;
    return 16'((s + 32768) >> 16);
  endfunction

  function automatic logic signed [15:0] wave_sine(input int unsigned idx);
    int unsigned p;
    int unsigned quad;
    logic signed [15:0] mag;
    p = idx % 256;
    quad = p / 64;
    mag = quad[0] ? sine_quarter(64 - p % 64) : sine_quarter(p % 64);
    return (quad >= 2) ? -mag : mag;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 30;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint corner_surflet(input longint dx, input longint dy,
                                            input int unsigned h);
    longint unsigned d2;
    longint unsigned d;
    longint unsigned q;
    longint unsigned w;
    longint unsigned dcu;
    longint unsigned neg;
    longint fd;
    longint dot;
    d2 = longint'(dx * dx + dy * dy);
    if (d2 >= (64'd1 << 32)) return 0;
    d = int_sqrt(d2);
    q = (15 * d * ONE16 - 6 * d * d) >> 16;
    w = 10 * ONE16 - q;
    dcu = (((d * d) >> 16) * d) >> 16;
    neg = (dcu * w) >> 16;
    fd = (neg >= ONE16) ? 0 : longint'(ONE16 - neg);
    dot = longint'(cos_rom[h]) * dx + longint'(sin_rom[h]) * dy;
    return (fd * dot) / 65536;
  endfunction

  function automatic longint octave_sum(input longint unsigned ax,
                                        input longint unsigned ay, input int k);
    longint unsigned sx;
    longint unsigned sy;
    longint fx;
    longint fy;
    longint sum;
    int unsigned first;
    int unsigned h;
    sx = (ax * FREQ) >> (16 - (k % 16));
    sy = (ay * FREQ) >> (16 - (k % 16));
    fx = longint'((sx >> 16) & 64'hFFFF);
    fy = longint'((sy >> 16) & 64'hFFFF);
    sum = 0;
    for (int cy = 0; cy < 2; cy++) begin
      for (int cx = 0; cx < 2; cx++) begin
        first = perm[8'((sx >> 32) + cx)];
        h = perm[8'(first + (sy >> 32) + cy)];
        sum += corner_surflet(fx - cx * longint'(ONE16), fy - cy * longint'(ONE16), h);
      end
    end
    return sum;
  endfunction

  function automatic longint unsigned coord_magnitude(input logic [31:0] c);
    return c[31] ? (64'h1_0000_0000 - longint'(c)) : longint'(c);
  endfunction

  function automatic logic signed [15:0] predict_noise(input logic [31:0] x,
                                                       input logic [31:0] y);
    longint num;
    longint unsigned mag;
    longint unsigned div;
    longint unsigned q;
    num = 0;
    for (int k = 0; k < OCTAVES; k++)
      num += octave_sum(coord_magnitude(x), coord_magnitude(y), k) *
             (longint'(1) << (OCTAVES - 1 - k));
    div = ((64'd1 << OCTAVES) - 1) * ONE16;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + div / 2) / div;
    if (num < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH %s at %0t", what, $realtime);
    error_count++;
  endtask

  task automatic queue_load(input int idx, input int value);
    request_t r;
    r = '{OP_LOAD, 8'(idx), 8'(value), $urandom(), $urandom(), 1'b0};
    pending_requests.push_back(r);
  endtask

  task automatic queue_point(input logic [31:0] x, input logic [31:0] y, input bit drain);
    request_t r;
    r = '{OP_POINT, 8'($urandom()), 8'($urandom()), x, y, drain};
    pending_requests.push_back(r);
  endtask

  initial begin
    items_if.valid = 1'b0;
    items_if.operation = OP_LOAD;
    items_if.table_index = '0;
    items_if.table_value = '0;
    items_if.x_coord = '0;
    items_if.y_coord = '0;
    results_if.ready = 1'b0;
  end

  // Sender: a new item is offered once the previous one has been transferred.
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
    end else if (!items_if.valid || items_if.ready) begin
      if (pending_requests.size() > 0 &&
          !(pending_requests[0].drain &&
            (expected_noise.size() != 0 || results_if.valid || items_if.valid)) &&
          $urandom_range(99) >= send_idle_pct) begin
        items_if.valid <= 1'b1;
        items_if.operation <= pending_requests[0].operation;
        items_if.table_index <= pending_requests[0].table_index;
        items_if.table_value <= pending_requests[0].table_value;
        items_if.x_coord <= pending_requests[0].x_coord;
        items_if.y_coord <= pending_requests[0].y_coord;
        void'(pending_requests.pop_front());
      end else begin
        items_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) results_if.ready <= 1'b0;
    else results_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        if (expected_noise.size() == 0) begin
          report_mismatch($sformatf("unexpected noise value %0d",
                                    results_if.noise_value));
        end else begin
          if (results_if.noise_value !== expected_noise[0])
            report_mismatch($sformatf("noise_value: expected %0d, got %0d",
                                      expected_noise[0], results_if.noise_value));
          void'(expected_noise.pop_front());
          results_checked++;
        end
      end
      if (items_if.valid && items_if.ready) begin
        accepted_count++;
        if (items_if.operation == OP_LOAD) begin
          perm[items_if.table_index] = items_if.table_value;
          loads_sent++;
        end else begin
          expected_noise.push_back(predict_noise(items_if.x_coord, items_if.y_coord));
          points_sent++;
        end
      end
    end
  end

  // A long hold-off on the result side while requests keep coming.
  initial begin
    recv_hold = 1'b0;
    wait (accepted_count >= 200);
    @(posedge clk);
    recv_hold = 1'b1;
    for (int i = 0; i < 3000; i++) @(posedge clk);
    recv_hold = 1'b0;
  end

  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", expected_noise.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int slots[256];
    int j;
    int tmp;
    logic [31:0] rx;
    logic [31:0] ry;
    error_count = 0;
    accepted_count = 0;
    loads_sent = 0;
    points_sent = 0;
    results_checked = 0;
    send_idle_pct = 7;
    recv_idle_pct = 77;
    for (int i = 0; i < 256; i++) begin
      cos_rom[i] = wave_sine(i + 64);
      sin_rom[i] = wave_sine(i);
      perm[i] = '0;
      slots[i] = i;
    end
    // Every entry is written first so that no point reads an unwritten one.
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    end
    for (int i = 0; i < 256; i++) queue_load(i, slots[i]);
    queue_load(0, 255);
    queue_load(255, 0);

    // Directed points: origin, lattice and half-cell positions, and extremes.
    queue_point(32'h0, 32'h0, 1'b0);
    queue_point(32'h1, 32'h1, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    queue_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_point(32'h0001_0000, 32'h0000_8000, 1'b0);
    queue_point(32'h0014_0000, 32'hFFEC_0000, 1'b0);
    queue_point(32'h000A_0000, 32'h000A_0000, 1'b0);
    queue_point(32'h0140_0000, 32'h00A0_0000, 1'b0);
    queue_point(32'hFFFF_0000, 32'h0000_FFFF, 1'b0);
    queue_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    queue_point(32'h0003_2000, 32'h0007_9000, 1'b1);

    wait (pending_requests.size() == 0);
    for (int n = 0; n < 930; n++) begin
      if (n == 310) begin
        wait (pending_requests.size() == 0);
        send_idle_pct = 77;
        recv_idle_pct = 7;
      end else if (n == 620) begin
        wait (pending_requests.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(99) < 20) begin
        queue_load($urandom_range(255), $urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0: begin
            rx = $urandom();
            ry = $urandom();
          end
          1: begin
            rx = 32'($signed($urandom_range(2_000_000)) - 1_000_000);
            ry = 32'($signed($urandom_range(2_000_000)) - 1_000_000);
          end
          2: begin
            rx = 32'($signed($urandom_range(200_000_000)) - 100_000_000);
            ry = 32'($signed($urandom_range(200_000_000)) - 100_000_000);
          end
          default: begin
            rx = {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom())};
            ry = {16'($urandom()), 16'($urandom())};
          end
        endcase
        queue_point(rx, ry, n == 465);
      end
      if (pending_requests.size() > 50) wait (pending_requests.size() < 10);
    end

    wait (pending_requests.size() == 0);
    @(posedge clk);
    wait (!items_if.valid);
    wait (expected_noise.size() == 0);
    for (int i = 0; i < 800; i++) @(posedge clk);
    if (expected_noise.size() != 0) begin
      report_mismatch($sformatf("%0d noise values never arrived", expected_noise.size()));
    end
    $display("Sent %0d table loads and %0d sample points; %0d noise values checked.",
             loads_sent, points_sent, results_checked);
    $display("Idling on each side, a long result hold-off and a full drain were covered.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", error_count);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
